// ===== rtl/core/brx_pkg.sv =====
// Package for the bitmap run extent extractor.
// Default sizes, queue depth and the width of the front-to-back descriptor.
// No dependencies.
`default_nettype none

package brx_pkg;

  // Default block number width and bitmap bits per beat
  localparam int unsigned BlockNumberBits = 48;
  localparam int unsigned BitsPerItem     = 8;

  // Entries in the descriptor queue between front and back
  localparam int unsigned QueueDepth = 4;

  // Packed width of one descriptor: two bit masks, seven block-sized fields
  // (four of them one bit wider) and five flags
  function automatic int unsigned desc_bits(int unsigned bnb, int unsigned bpi);
    return 2 * bpi + 7 * bnb + 9;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/brx_if.sv =====
// Stream interfaces of the bitmap run extent extractor: config, bitmap in, extents out.
// Depends on brx_pkg for default widths.
`default_nettype none

// Configuration write channel: first block number of the scan
interface brx_cfg_if #(
  parameter int unsigned BlockNumberBits = brx_pkg::BlockNumberBits
);
  logic                       valid;
  logic                       ready;
  logic [BlockNumberBits-1:0] first_block;

  modport source (output valid, first_block, input ready);
  modport sink   (input valid, first_block, output ready);
endinterface

// Bitmap input channel
interface brx_in_if #(
  parameter int unsigned BitsPerItem = brx_pkg::BitsPerItem
);
  localparam int unsigned VldW = $clog2(BitsPerItem + 1);

  logic                   valid;
  logic                   ready;
  logic [BitsPerItem-1:0] bitmap_byte;
  logic [VldW-1:0]        valid_bits;
  logic                   end_of_scan;

  modport source (output valid, bitmap_byte, valid_bits, end_of_scan, input ready);
  modport sink   (input valid, bitmap_byte, valid_bits, end_of_scan, output ready);
endinterface

// Extent output channel
interface brx_out_if #(
  parameter int unsigned BlockNumberBits = brx_pkg::BlockNumberBits
);
  logic                     valid;
  logic                     ready;
  logic [BlockNumberBits-1:0] extent_start;
  logic [BlockNumberBits:0]   extent_length;
  logic                     extent_used;
  logic [BlockNumberBits:0]   used_total;
  logic [BlockNumberBits:0]   free_total;
  logic                     final_result;
  logic                     last_of_item;

  modport source (output valid, extent_start, extent_length, extent_used, used_total,
                  free_total, final_result, last_of_item, input ready);
  modport sink   (input valid, extent_start, extent_length, extent_used, used_total,
                  free_total, final_result, last_of_item, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/bitmap_run_extent_extractor_unit.sv =====
// Bitmap run extent extractor, top level: front, descriptor queue, back.
// The first extent of a beat passes the queue and the back-end output register.
// One bitmap beat per cycle while each yields at most one extent and the sink is
// ready; more extents in a beat hold the back end, the 4-entry queue absorbs bursts.
// Reset clears run state, totals, queue and output; first_block resets to 0.
// Depends on brx_pkg, brx_if, brx_front, brx_queue, brx_back.
`default_nettype none

module bitmap_run_extent_extractor_unit #(
  parameter int unsigned BlockNumberBits = brx_pkg::BlockNumberBits,
  parameter int unsigned BitsPerItem     = brx_pkg::BitsPerItem,
  parameter int unsigned QueueDepth      = brx_pkg::QueueDepth
) (
  input  logic clk_i,
  input  logic rst_ni,
  brx_cfg_if.sink   cfg_i,
  brx_in_if.sink    bitmap_i,
  brx_out_if.source extent_o
);
  import brx_pkg::*;

  localparam int unsigned DescW = desc_bits(BlockNumberBits, BitsPerItem);

  logic             push;
  logic             pop;
  logic             full;
  logic             empty;
  logic [DescW-1:0] desc_in;
  logic [DescW-1:0] desc_out;

  // Front: accept beats, find breaks
  brx_front #(
    .BlockNumberBits (BlockNumberBits),
    .BitsPerItem     (BitsPerItem)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_i),
    .bitmap_i (bitmap_i),
    .full_i   (full),
    .push_o   (push),
    .desc_o   (desc_in)
  );

  // Decoupling queue
  brx_queue #(
    .Width (DescW),
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (desc_in),
    .pop_i   (pop),
    .data_o  (desc_out),
    .full_o  (full),
    .empty_o (empty)
  );

  // Back: emit extents
  brx_back #(
    .BlockNumberBits (BlockNumberBits),
    .BitsPerItem     (BitsPerItem)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .desc_i   (desc_out),
    .empty_i  (empty),
    .pop_o    (pop),
    .extent_o (extent_o)
  );

endmodule

`default_nettype wire

// ===== rtl/core/brx_front.sv =====
// Front end: accepts bitmap beats, tracks the open run and totals, finds run breaks
// and pushes one descriptor per beat that yields extents. Depends on brx_pkg, brx_if.
`default_nettype none

module brx_front #(
  parameter int unsigned BlockNumberBits = brx_pkg::BlockNumberBits,
  parameter int unsigned BitsPerItem     = brx_pkg::BitsPerItem
) (
  input  logic clk_i,
  input  logic rst_ni,
  brx_cfg_if.sink cfg_i,
  brx_in_if.sink  bitmap_i,
  input  logic full_i,
  output logic push_o,
  output logic [brx_pkg::desc_bits(BlockNumberBits, BitsPerItem)-1:0] desc_o
);
  import brx_pkg::*;

  localparam int unsigned Bnb  = BlockNumberBits;
  localparam int unsigned Bpi  = BitsPerItem;
  localparam int unsigned VldW = $clog2(Bpi + 1);
  localparam int unsigned IdxW = (Bpi > 1) ? $clog2(Bpi) : 1;

  typedef struct packed {
    logic [Bpi-1:0] brk;
    logic [Bpi-1:0] bits;
    logic [Bnb-1:0] base;
    logic           ent_open;
    logic [Bnb-1:0] ent_start;
    logic [Bnb:0]   ent_len;
    logic           ent_used;
    logic           eos;
    logic           fin_open;
    logic [Bnb-1:0] fin_start;
    logic [Bnb:0]   fin_len;
    logic           fin_used;
    logic [Bnb:0]   used_tot;
    logic [Bnb:0]   free_tot;
  } desc_t;

  localparam logic [Bnb:0] CntSat = {1'b1, {Bnb{1'b0}}};

  logic [Bnb-1:0] first_block_q;
  logic           run_open_q, run_open_d;
  logic           open_used_q, open_used_d;
  logic [Bnb-1:0] open_start_q, open_start_d;
  logic [Bnb:0]   open_len_q, open_len_d;
  logic [Bnb-1:0] next_blk_q, next_blk_d;
  logic [Bnb:0]   used_cnt_q, used_cnt_d;
  logic [Bnb:0]   free_cnt_q, free_cnt_d;

  logic           accept;
  logic [VldW-1:0] nv;
  logic [VldW-1:0] nv_m1;
  logic [Bnb-1:0] eff_next;
  logic [Bpi-1:0] vmask;
  logic [Bpi-1:0] brk;
  logic [Bpi-1:0] strt;
  logic [IdxW-1:0] last_strt;
  logic [VldW-1:0] pop_used;
  logic [Bnb+1:0] used_sum;
  logic [Bnb+1:0] free_sum;
  logic           post_open;
  logic           post_used;
  logic [Bnb-1:0] post_start;
  logic [Bnb:0]   post_len;
  logic [Bnb:0]   used_new;
  logic [Bnb:0]   free_new;
  desc_t          desc;

  assign cfg_i.ready    = 1'b1;
  assign bitmap_i.ready = !full_i;
  assign accept         = bitmap_i.valid && bitmap_i.ready;

  // Clamp the bit count and pick the block number of bit 0
  always_comb begin
    nv       = (bitmap_i.valid_bits > VldW'(Bpi)) ? VldW'(Bpi) : bitmap_i.valid_bits;
    nv_m1    = nv - VldW'(1);
    eff_next = run_open_q ? next_blk_q : first_block_q;
  end

  // Per-bit run breaks: value change or block number wrap to zero
  always_comb begin
    for (int i = 0; i < Bpi; i++) begin
      vmask[i] = VldW'(i) < nv;
      if (i == 0) begin
        brk[i]  = vmask[i] && run_open_q &&
                  ((bitmap_i.bitmap_byte[i] != open_used_q) || (eff_next == '0));
        strt[i] = brk[i] || (vmask[i] && !run_open_q);
      end else begin
        brk[i]  = vmask[i] &&
                  ((bitmap_i.bitmap_byte[i] != bitmap_i.bitmap_byte[i-1]) ||
                   ((eff_next + Bnb'(i)) == '0));
        strt[i] = brk[i];
      end
    end
  end

  // Last run start inside the beat and used-bit count
  always_comb begin
    last_strt = '0;
    pop_used  = '0;
    for (int i = 0; i < Bpi; i++) begin
      if (strt[i]) begin
        last_strt = IdxW'(i);
      end
      pop_used = pop_used + VldW'(bitmap_i.bitmap_byte[i] & vmask[i]);
    end
  end

  // Open run after the beat
  always_comb begin
    post_open = run_open_q || (nv != '0);
    post_used = (nv != '0) ? bitmap_i.bitmap_byte[nv_m1[IdxW-1:0]] : open_used_q;
    if (|strt) begin
      post_start = eff_next + Bnb'(last_strt);
      post_len   = (Bnb+1)'(nv) - (Bnb+1)'(last_strt);
    end else begin
      post_start = open_start_q;
      post_len   = open_len_q + (Bnb+1)'(nv);
    end
  end

  // Saturating totals
  always_comb begin
    used_sum = {1'b0, used_cnt_q} + (Bnb+2)'(pop_used);
    free_sum = {1'b0, free_cnt_q} + (Bnb+2)'(nv - pop_used);
    used_new = (used_sum > (Bnb+2)'(CntSat)) ? CntSat : used_sum[Bnb:0];
    free_new = (free_sum > (Bnb+2)'(CntSat)) ? CntSat : free_sum[Bnb:0];
  end

  // Descriptor for the back end
  always_comb begin
    desc.brk       = brk;
    desc.bits      = bitmap_i.bitmap_byte;
    desc.base      = eff_next;
    desc.ent_open  = run_open_q;
    desc.ent_start = open_start_q;
    desc.ent_len   = open_len_q;
    desc.ent_used  = open_used_q;
    desc.eos       = bitmap_i.end_of_scan;
    desc.fin_open  = post_open;
    desc.fin_start = post_start;
    desc.fin_len   = post_len;
    desc.fin_used  = post_used;
    desc.used_tot  = used_new;
    desc.free_tot  = free_new;
  end

  assign desc_o = desc;
  assign push_o = accept && ((|brk) || bitmap_i.end_of_scan);

  // Scan state update; end of scan returns run state and totals to reset
  always_comb begin
    run_open_d   = run_open_q;
    open_used_d  = open_used_q;
    open_start_d = open_start_q;
    open_len_d   = open_len_q;
    next_blk_d   = next_blk_q;
    used_cnt_d   = used_cnt_q;
    free_cnt_d   = free_cnt_q;
    if (accept) begin
      if (bitmap_i.end_of_scan) begin
        run_open_d   = 1'b0;
        open_used_d  = 1'b0;
        open_start_d = '0;
        open_len_d   = '0;
        next_blk_d   = '0;
        used_cnt_d   = '0;
        free_cnt_d   = '0;
      end else begin
        run_open_d   = post_open;
        open_used_d  = post_used;
        open_start_d = post_start;
        open_len_d   = post_len;
        next_blk_d   = eff_next + Bnb'(nv);
        used_cnt_d   = used_new;
        free_cnt_d   = free_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_block_q <= '0;
      run_open_q    <= 1'b0;
      open_used_q   <= 1'b0;
      open_start_q  <= '0;
      open_len_q    <= '0;
      next_blk_q    <= '0;
      used_cnt_q    <= '0;
      free_cnt_q    <= '0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        first_block_q <= cfg_i.first_block;
      end
      run_open_q   <= run_open_d;
      open_used_q  <= open_used_d;
      open_start_q <= open_start_d;
      open_len_q   <= open_len_d;
      next_blk_q   <= next_blk_d;
      used_cnt_q   <= used_cnt_d;
      free_cnt_q   <= free_cnt_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/brx_queue.sv =====
// Short descriptor queue between front and back of the run extent extractor.
// Register array with head read; depends on brx_pkg for the default depth.
`default_nettype none

module brx_queue #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = brx_pkg::QueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             full_o,
  output logic             empty_o
);
  import brx_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  // Pointer wrap at the depth, which need not be a power of two
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage, no reset
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  // Front only pushes while there is room; back only pops a present entry
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("queue pop while empty");

endmodule

`default_nettype wire

// ===== rtl/core/brx_back.sv =====
// Back end: expands a descriptor into extents, one beat per cycle while the
// sink is ready; appends totals on end of scan. Depends on brx_pkg, brx_if.
`default_nettype none

module brx_back #(
  parameter int unsigned BlockNumberBits = brx_pkg::BlockNumberBits,
  parameter int unsigned BitsPerItem     = brx_pkg::BitsPerItem
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic [brx_pkg::desc_bits(BlockNumberBits, BitsPerItem)-1:0] desc_i,
  input  logic empty_i,
  output logic pop_o,
  brx_out_if.source extent_o
);
  import brx_pkg::*;

  localparam int unsigned Bnb  = BlockNumberBits;
  localparam int unsigned Bpi  = BitsPerItem;
  localparam int unsigned IdxW = (Bpi > 1) ? $clog2(Bpi) : 1;

  typedef struct packed {
    logic [Bpi-1:0] brk;
    logic [Bpi-1:0] bits;
    logic [Bnb-1:0] base;
    logic           ent_open;
    logic [Bnb-1:0] ent_start;
    logic [Bnb:0]   ent_len;
    logic           ent_used;
    logic           eos;
    logic           fin_open;
    logic [Bnb-1:0] fin_start;
    logic [Bnb:0]   fin_len;
    logic           fin_used;
    logic [Bnb:0]   used_tot;
    logic [Bnb:0]   free_tot;
  } desc_t;

  desc_t d;
  assign d = desc_i;

  // Walk state within the head descriptor
  logic            fresh_q, fresh_d;
  logic [Bpi-1:0]  rem_q, rem_d;
  logic [IdxW-1:0] pos_q, pos_d;
  logic            pos_vld_q, pos_vld_d;

  // Output register
  logic            out_valid_q, out_valid_d;
  logic [Bnb-1:0]  out_start_q, out_start_d;
  logic [Bnb:0]    out_len_q, out_len_d;
  logic            out_used_q, out_used_d;
  logic [Bnb:0]    out_utot_q, out_utot_d;
  logic [Bnb:0]    out_ftot_q, out_ftot_d;
  logic            out_final_q, out_final_d;
  logic            out_last_q, out_last_d;

  logic            emit;
  logic [Bpi-1:0]  cur_rem;
  logic [IdxW-1:0] cur_pos;
  logic            cur_pos_vld;
  logic [IdxW-1:0] brk_pos;
  logic [Bpi-1:0]  rem_after;

  assign emit = !empty_i && (!out_valid_q || extent_o.ready);

  always_comb begin
    cur_rem     = fresh_q ? d.brk : rem_q;
    cur_pos     = fresh_q ? '0 : pos_q;
    cur_pos_vld = fresh_q ? !d.ent_open : pos_vld_q;
  end

  // Lowest pending break
  always_comb begin
    brk_pos = '0;
    for (int i = Bpi - 1; i >= 0; i--) begin
      if (cur_rem[i]) begin
        brk_pos = IdxW'(i);
      end
    end
    rem_after = cur_rem & ~(Bpi'(1) << brk_pos);
  end

  // Next extent beat: a closed run, or the final run with totals
  always_comb begin
    out_start_d = out_start_q;
    out_len_d   = out_len_q;
    out_used_d  = out_used_q;
    out_utot_d  = out_utot_q;
    out_ftot_d  = out_ftot_q;
    out_final_d = out_final_q;
    out_last_d  = out_last_q;
    pop_o       = 1'b0;
    fresh_d     = fresh_q;
    rem_d       = rem_q;
    pos_d       = pos_q;
    pos_vld_d   = pos_vld_q;
    if (emit) begin
      out_utot_d  = '0;
      out_ftot_d  = '0;
      out_final_d = 1'b0;
      if (|cur_rem) begin
        // run that closes at the break started in this beat or came in open
        if (cur_pos_vld) begin
          out_start_d = d.base + Bnb'(cur_pos);
          out_len_d   = (Bnb+1)'(brk_pos) - (Bnb+1)'(cur_pos);
          out_used_d  = d.bits[cur_pos];
        end else begin
          out_start_d = d.ent_start;
          out_len_d   = d.ent_len + (Bnb+1)'(brk_pos);
          out_used_d  = d.ent_used;
        end
        out_last_d = (rem_after == '0) && !d.eos;
        rem_d      = rem_after;
        pos_d      = brk_pos;
        pos_vld_d  = 1'b1;
      end else begin
        // end of scan: flush the open run, or a totals-only beat
        out_start_d = d.fin_open ? d.fin_start : '0;
        out_len_d   = d.fin_open ? d.fin_len : '0;
        out_used_d  = d.fin_open && d.fin_used;
        out_utot_d  = d.used_tot;
        out_ftot_d  = d.free_tot;
        out_final_d = 1'b1;
        out_last_d  = 1'b1;
      end
      pop_o   = out_last_d;
      fresh_d = out_last_d;
    end
  end

  always_comb begin
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (extent_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fresh_q     <= 1'b1;
      rem_q       <= '0;
      pos_q       <= '0;
      pos_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      fresh_q     <= fresh_d;
      rem_q       <= rem_d;
      pos_q       <= pos_d;
      pos_vld_q   <= pos_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_start_q <= out_start_d;
    out_len_q   <= out_len_d;
    out_used_q  <= out_used_d;
    out_utot_q  <= out_utot_d;
    out_ftot_q  <= out_ftot_d;
    out_final_q <= out_final_d;
    out_last_q  <= out_last_d;
  end

  assign extent_o.valid         = out_valid_q;
  assign extent_o.extent_start  = out_start_q;
  assign extent_o.extent_length = out_len_q;
  assign extent_o.extent_used   = out_used_q;
  assign extent_o.used_total    = out_utot_q;
  assign extent_o.free_total    = out_ftot_q;
  assign extent_o.final_result  = out_final_q;
  assign extent_o.last_of_item  = out_last_q;

  // A beat that ends the scan also ends its descriptor
  a_final_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_final_q) |-> out_last_q) else $error("final beat not last");
  // Totals only travel on the final beat
  a_totals_on_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_final_q) |-> (out_utot_q == '0 && out_ftot_q == '0))
    else $error("totals on non-final beat");

endmodule

`default_nettype wire

// ===== sim/tb_bitmap_run_extent_extractor_unit.sv =====
// Testbench for bitmap_run_extent_extractor_unit: directed and random bitmap scans checked
// against an extent tracker that predicts every run, flush and totals beat.
// Depends on brx_pkg, brx_if and the RTL of the unit.

// One extent beat as it leaves the block
typedef struct packed {
  logic [brx_pkg::BlockNumberBits-1:0] start;
  logic [brx_pkg::BlockNumberBits:0]   length;
  logic                                used;
  logic [brx_pkg::BlockNumberBits:0]   used_total;
  logic [brx_pkg::BlockNumberBits:0]   free_total;
  logic                                final_flag;
  logic                                last_flag;
} extent_rec_t;

// Tracks the open run and the totals, queues the extents each bitmap beat closes
class ExtentTracker;
  localparam int unsigned Bnb = brx_pkg::BlockNumberBits;
  localparam int unsigned Bpi = brx_pkg::BitsPerItem;
  localparam logic [Bnb:0] CountCap = {1'b1, {Bnb{1'b0}}};

  logic [Bnb-1:0] scan_base;
  logic           run_open;
  logic           run_used;
  logic [Bnb-1:0] open_start;
  logic [Bnb:0]   run_len;
  logic [Bnb-1:0] next_blk;
  logic [Bnb:0]   used_cnt;
  logic [Bnb:0]   free_cnt;
  extent_rec_t    pending_extents[$];
  int             mismatches;

  function new();
    scan_base  = '0;
    mismatches = 0;
    clear_scan();
  endfunction

  function void clear_scan();
    run_open   = 1'b0;
    run_used   = 1'b0;
    open_start = '0;
    run_len    = '0;
    next_blk   = '0;
    used_cnt   = '0;
    free_cnt   = '0;
  endfunction

  function void set_scan_base(logic [Bnb-1:0] value);
    scan_base = value;
  endfunction

  function int pending();
    return pending_extents.size();
  endfunction

  function extent_rec_t closed_run(logic [Bnb-1:0] start, logic [Bnb:0] len, logic used);
    extent_rec_t rec;
    rec            = '0;
    rec.start      = start;
    rec.length     = len;
    rec.used       = used;
    return rec;
  endfunction

  // Accepted bitmap beat: walk its bits and queue whatever extents close
  function void take_bitmap_beat(logic [Bpi-1:0] bits, int unsigned nvalid, logic eos);
    extent_rec_t    fresh[$];
    extent_rec_t    tail;
    logic           used;
    logic [Bnb-1:0] blk;
    logic [Bnb+1:0] run_end;
    int unsigned    n;
    n = (nvalid > Bpi) ? Bpi : nvalid;
    // no open run: numbering restarts at the configured base
    if (!run_open) next_blk = scan_base;
    for (int i = 0; i < n; i++) begin
      used    = bits[i];
      blk     = next_blk;
      run_end = open_start + run_len;
      if (!run_open) begin
        run_open   = 1'b1;
        run_used   = used;
        open_start = blk;
        run_len    = (Bnb+1)'(1);
      end else if (used == run_used && run_end == {2'b00, blk}) begin
        run_len = run_len + 1'b1;
      end else begin
        // bit flip or block number wrap closes the run
        tail  = closed_run(open_start, run_len, run_used);
        fresh = {fresh, tail};
        run_used   = used;
        open_start = blk;
        run_len    = (Bnb+1)'(1);
      end
      if (used) begin
        if (used_cnt < CountCap) used_cnt = used_cnt + 1'b1;
      end else begin
        if (free_cnt < CountCap) free_cnt = free_cnt + 1'b1;
      end
      next_blk = blk + 1'b1;
    end
    // end of scan: flush the run, or a totals-only beat when nothing is open
    if (eos) begin
      tail            = run_open ? closed_run(open_start, run_len, run_used)
                                 : closed_run('0, '0, 1'b0);
      tail.used_total = used_cnt;
      tail.free_total = free_cnt;
      tail.final_flag = 1'b1;
      fresh = {fresh, tail};
      clear_scan();
    end
    if (fresh.size() > 0) begin
      fresh[fresh.size() - 1].last_flag = 1'b1;
    end
    foreach (fresh[k]) pending_extents = {pending_extents, fresh[k]};
  endfunction

  function void compare_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
    end
  endfunction

  // Output beat: compare against the oldest queued extent
  function void match_extent(extent_rec_t got);
    extent_rec_t want;
    if (pending_extents.size() == 0) begin
      mismatches++;
      $display("%0t: extent beat with none queued, expected nothing, got start %h len %h",
               $time, got.start, got.length);
      return;
    end
    want = pending_extents[0];
    pending_extents.delete(0);
    compare_field("extent_start", want.start, got.start);
    compare_field("extent_length", want.length, got.length);
    compare_field("extent_used", want.used, got.used);
    compare_field("used_total", want.used_total, got.used_total);
    compare_field("free_total", want.free_total, got.free_total);
    compare_field("final_result", want.final_flag, got.final_flag);
    compare_field("last_of_item", want.last_flag, got.last_flag);
  endfunction
endclass

module tb_bitmap_run_extent_extractor_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Bnb  = brx_pkg::BlockNumberBits;
  localparam int unsigned Bpi  = brx_pkg::BitsPerItem;
  localparam int unsigned VldW = $clog2(Bpi + 1);
  localparam logic [Bnb-1:0] BlockMax = {Bnb{1'b1}};

  logic clk_i = 1'b0;
  logic rst_ni;

  brx_cfg_if cfg_ch ();
  brx_in_if  bitmap_ch ();
  brx_out_if extent_ch ();

  bitmap_run_extent_extractor_unit i_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_ch),
    .bitmap_i (bitmap_ch),
    .extent_o (extent_ch)
  );

  ExtentTracker tracker;
  extent_rec_t  seen;
  int unsigned  tx_idle_pct = 0;
  int unsigned  rx_idle_pct = 0;
  int unsigned  hold_ask    = 0;
  int unsigned  hold_grant  = 0;
  int unsigned  hold_left   = 0;

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Run limit
  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

  // Extent sink: random stalls, plus a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_grant != hold_ask) begin
      hold_grant = hold_ask;
      hold_left  = 120;
    end
    if (hold_left != 0) begin
      hold_left--;
      extent_ch.ready <= 1'b0;
    end else begin
      extent_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Monitor: config, bitmap and extent beats in one place so their order is fixed
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_ch.valid && cfg_ch.ready) tracker.set_scan_base(cfg_ch.first_block);
      if (bitmap_ch.valid && bitmap_ch.ready)
        tracker.take_bitmap_beat(bitmap_ch.bitmap_byte, bitmap_ch.valid_bits,
                                 bitmap_ch.end_of_scan);
      if (extent_ch.valid && extent_ch.ready) begin
        seen = '{start:      extent_ch.extent_start,
                 length:     extent_ch.extent_length,
                 used:       extent_ch.extent_used,
                 used_total: extent_ch.used_total,
                 free_total: extent_ch.free_total,
                 final_flag: extent_ch.final_result,
                 last_flag:  extent_ch.last_of_item};
        tracker.match_extent(seen);
      end
    end
  end

  task automatic send_beat(input logic [Bpi-1:0] bits, input logic [VldW-1:0] nbits,
                           input logic eos);
    while ($urandom_range(99) < tx_idle_pct) begin
      bitmap_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    bitmap_ch.valid       <= 1'b1;
    bitmap_ch.bitmap_byte <= bits;
    bitmap_ch.valid_bits  <= nbits;
    bitmap_ch.end_of_scan <= eos;
    do @(posedge clk_i); while (!bitmap_ch.ready);
  endtask

  // Let the monitor see the last beat, wait out queued extents, then a margin
  task automatic drain();
    bitmap_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  task automatic write_first_block(input logic [Bnb-1:0] value);
    cfg_ch.first_block <= value;
    cfg_ch.valid       <= 1'b1;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  // Random scans: random, solid and split bytes, with odd widths and early ends mixed in
  task automatic run_scans(input int unsigned count);
    int unsigned     sent;
    int unsigned     scan_len;
    int unsigned     k;
    int unsigned     pick;
    logic [Bpi-1:0]  bits;
    logic [VldW-1:0] nbits;
    logic            eos;
    sent = 0;
    while (sent < count) begin
      scan_len = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      for (k = 0; k < scan_len && sent < count; k++) begin
        pick = $urandom_range(99);
        if (pick < 30) begin
          bits = Bpi'($urandom);
        end else if (pick < 52) begin
          bits = '1;
        end else if (pick < 74) begin
          bits = '0;
        end else begin
          bits = {Bpi{1'b1}} << $urandom_range(0, Bpi);
          if ($urandom_range(1) == 1) bits = ~bits;
        end
        pick = $urandom_range(99);
        if (pick < 80) nbits = VldW'(Bpi);
        else if (pick < 92) nbits = VldW'($urandom_range(1, Bpi - 1));
        else if (pick < 96) nbits = '0;
        else nbits = VldW'($urandom_range(Bpi + 1, (1 << VldW) - 1));
        eos = (k == scan_len - 1) || ($urandom_range(49) == 0);
        send_beat(bits, nbits, eos);
        if (nbits != 0 || eos) sent++;
      end
    end
  endtask

  initial begin
    int unsigned waited;
    tracker               = new();
    rst_ni                = 1'b0;
    cfg_ch.valid          = 1'b0;
    cfg_ch.first_block    = '0;
    bitmap_ch.valid       = 1'b0;
    bitmap_ch.bitmap_byte = '0;
    bitmap_ch.valid_bits  = '0;
    bitmap_ch.end_of_scan = 1'b0;
    extent_ch.ready       = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // sender mostly busy, sink mostly stalled
    tx_idle_pct = 26;
    rx_idle_pct = 84;

    // directed: solid, alternating, odd widths, empty end, flush on zero width
    write_first_block('0);
    send_beat(8'hFF, 4'd8, 1'b0);
    send_beat(8'h00, 4'd8, 1'b0);
    send_beat(8'h55, 4'd8, 1'b0);
    send_beat(8'hAA, 4'd8, 1'b1);
    send_beat(8'h00, 4'd0, 1'b1);
    send_beat(8'h3C, 4'd0, 1'b0);
    send_beat(8'hF0, 4'd4, 1'b0);
    send_beat(8'hFF, 4'd15, 1'b0);
    send_beat(8'h81, 4'd9, 1'b0);
    send_beat(8'h7E, 4'd1, 1'b0);
    send_beat(8'h00, 4'd0, 1'b1);
    send_beat(8'h01, 4'd1, 1'b1);
    drain();

    // base written while a scan is open only applies to the next scan
    send_beat(8'h0F, 4'd8, 1'b0);
    drain();
    write_first_block(BlockMax);
    send_beat(8'hF0, 4'd8, 1'b1);
    send_beat(8'hFF, 4'd8, 1'b0);
    send_beat(8'hFF, 4'd8, 1'b1);
    drain();

    // wrap just after the scan starts
    write_first_block(BlockMax - 1'b1);
    send_beat(8'hFF, 4'd8, 1'b0);
    send_beat(8'h0F, 4'd10, 1'b0);
    send_beat(8'h80, 4'd12, 1'b1);
    send_beat(8'h00, 4'd0, 1'b1);
    drain();

    // random scans, first idling profile
    write_first_block(Bnb'({$urandom, $urandom}));
    run_scans(75);
    drain();
    write_first_block(BlockMax - 2'd2);
    run_scans(75);
    drain();

    // sender sparse, sink stalls rarely
    tx_idle_pct = 84;
    rx_idle_pct = 26;
    write_first_block('0);
    run_scans(75);
    drain();
    write_first_block(Bnb'({$urandom, $urandom}));
    run_scans(75);
    drain();

    // no idling; sink holds off long enough to back up the queue
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_first_block(BlockMax);
    hold_ask++;
    run_scans(75);
    drain();
    write_first_block(Bnb'($urandom_range(0, 1000)));
    run_scans(75);
    bitmap_ch.valid <= 1'b0;
    @(posedge clk_i);

    waited = 0;
    while (tracker.pending() != 0 && waited < 20000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (20) @(posedge clk_i);
    if (tracker.pending() != 0)
      $display("%0t: %0d extents never arrived", $time, tracker.pending());
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
